// ----- design/clf_pkg.sv -----
// Shared types and constants for the conservative Lagrangian flux unit.
`timescale 1ns / 1ps
`default_nettype none
package clf_pkg;

  typedef enum logic [1:0] {
    JOB_ZERO,
    JOB_ORD2,
    JOB_ORD4
  } job_kind_t;

  // one flux to work out; for second order fa is f(i) and fb is f(i+1),
  // for fourth order fa..fd are f(i+2), f(i+1), f(i), f(i-1)
  typedef struct packed {
    job_kind_t          kind;
    logic signed [31:0] fa;
    logic signed [31:0] fb;
    logic signed [31:0] fc;
    logic signed [31:0] fd;
    logic signed [31:0] sh;
    logic [32:0]        dx;
    logic [15:0]        idx;
    logic               last;
  } job_t;

  localparam int FIFO_DEPTH = 4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 2'd1;
  localparam logic [31:0] TIME_STEP_RESET  = 32'd65536;
  localparam logic        ORDER_MODE_RESET = 1'b1;

  // shared multiplier operand and result widths
  localparam int MX_W    = 40;
  localparam int MY_W    = 36;
  localparam int MR_W    = 44;
  localparam int DIG_W   = 8;
  localparam int Q_SHIFT = 30;

endpackage
`default_nettype wire

// ----- design/clf_fifo.sv -----
// Short request queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module clf_fifo import clf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output job_t rdata,
  output logic empty
);

  localparam int PW = $clog2(FIFO_DEPTH);

  job_t          mem [FIFO_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt == (PW+1)'(FIFO_DEPTH));
  assign empty   = (cnt == '0);
  assign rdata   = mem[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        mem[wp] <= wdata;
        wp      <= (wp == PW'(FIFO_DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == PW'(FIFO_DEPTH-1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (cnt == $past(cnt) + 1'b1))
    else $error("queue fill count lost a request");

endmodule
`default_nettype wire

// ----- design/clf_front.sv -----
// Front part: cell windows, cell counter and request classification.
`timescale 1ns / 1ps
`default_nettype none
module clf_front import clf_pkg::*; #(
  parameter int MAX_CELLS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] sample,
  input  logic signed [31:0] shift,
  input  logic signed [31:0] grid_pos,
  input  logic               last_in,
  input  logic               order_mode,
  output job_t               job_data,
  output logic               job_push,
  input  logic               job_full
);

  localparam int CW = $clog2(MAX_CELLS);

  logic signed [31:0] fw [4];
  logic signed [31:0] sw [3];
  logic signed [31:0] pw [3];
  logic [CW-1:0]      count;
  logic [CW-1:0]      j_r;
  logic               mode_r;
  logic [2:0]         pend;
  logic               accept;
  logic               last_eff;
  logic [1:0]         sel;
  logic [CW-1:0]      idx;
  logic [CW+15:0]     idx_w;

  function automatic logic [32:0] absdiff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  assign in_ready = (pend == '0);
  assign accept   = in_valid && in_ready;
  assign last_eff = last_in || (count >= CW'(MAX_CELLS - 1));
  assign job_push = (pend != '0) && !job_full;

  always_comb begin
    sel   = pend[2] ? 2'd2 : (pend[1] ? 2'd1 : 2'd0);
    idx   = j_r - CW'(sel);
    idx_w = {16'b0, idx};
    job_data      = '0;
    job_data.kind = JOB_ZERO;
    job_data.idx  = idx_w[15:0];
    job_data.last = (sel == 2'd0);
    if (mode_r) begin
      if (sel == 2'd2 && idx >= CW'(2)) begin
        job_data.kind = JOB_ORD4;
        job_data.fa   = fw[0];
        job_data.fb   = fw[1];
        job_data.fc   = fw[2];
        job_data.fd   = fw[3];
        job_data.sh   = sw[2];
        job_data.dx   = absdiff(pw[1], pw[2]);
      end
    end else if (idx >= CW'(1)) begin
      case (sel)
        2'd2: begin
          job_data.kind = JOB_ORD2;
          job_data.fa   = fw[2];
          job_data.fb   = fw[1];
          job_data.sh   = sw[2];
          job_data.dx   = absdiff(pw[1], pw[2]);
        end
        2'd1: begin
          job_data.kind = JOB_ORD2;
          job_data.fa   = fw[1];
          job_data.fb   = fw[0];
          job_data.sh   = sw[1];
          job_data.dx   = absdiff(pw[0], pw[1]);
        end
        default: job_data.kind = JOB_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= '0;
      for (int k = 0; k < 4; k++) fw[k] <= '0;
      for (int k = 0; k < 3; k++) begin
        sw[k] <= '0;
        pw[k] <= '0;
      end
    end else if (accept) begin
      fw[3]  <= fw[2];
      fw[2]  <= fw[1];
      fw[1]  <= fw[0];
      fw[0]  <= sample;
      sw[2]  <= sw[1];
      sw[1]  <= sw[0];
      sw[0]  <= shift;
      pw[2]  <= pw[1];
      pw[1]  <= pw[0];
      pw[0]  <= grid_pos;
      j_r    <= count;
      mode_r <= order_mode;
      pend   <= {count >= CW'(2), last_eff && (count >= CW'(1)), last_eff};
      count  <= last_eff ? '0 : count + 1'b1;
    end else if (job_push) begin
      pend[sel] <= 1'b0;
    end
  end

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && last_eff) |=> (count == '0))
    else $error("cell counter did not wrap at end of pencil");

  a_emit: assert property (@(posedge clk) disable iff (rst)
    (accept && (last_eff || count >= CW'(2))) |=> (pend != '0))
    else $error("accepted cell raised no request");

endmodule
`default_nettype wire

// ----- design/clf_mul.sv -----
// Shared multiplier: floor(x*y / 2^30), eight bits of y per cycle.
`timescale 1ns / 1ps
`default_nettype none
module clf_mul import clf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [MX_W-1:0] x,
  input  logic signed [MY_W-1:0] y,
  output logic signed [MR_W-1:0] res,
  output logic                   done
);

  localparam int NDIG  = (MY_W + DIG_W - 1) / DIG_W;
  localparam int UY_W  = NDIG * DIG_W;
  localparam int AW    = MX_W + UY_W;
  localparam int CNT_W = $clog2(NDIG);
  localparam logic [AW-1:0] RND = {{(AW-Q_SHIFT){1'b0}}, {Q_SHIFT{1'b1}}};

  logic [AW-1:0]    acc;
  logic [AW-1:0]    sx;
  logic [UY_W-1:0]  uy;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic             busy;
  logic             fin;
  logic [MX_W-1:0]  ux_abs;
  logic [MY_W-1:0]  uy_abs;
  logic [AW-1:0]    q_pos;
  logic [AW-1:0]    q_neg;

  assign ux_abs = x[MX_W-1] ? MX_W'(-x) : MX_W'(x);
  assign uy_abs = y[MY_W-1] ? MY_W'(-y) : MY_W'(y);
  assign q_pos  = acc >> Q_SHIFT;
  assign q_neg  = (acc + RND) >> Q_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sx   <= AW'(ux_abs);
        uy   <= UY_W'(uy_abs);
        neg  <= x[MX_W-1] ^ y[MY_W-1];
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc + AW'(sx * AW'(uy[DIG_W-1:0]));
        sx  <= sx << DIG_W;
        uy  <= uy >> DIG_W;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NDIG - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        res  <= neg ? MR_W'(~q_neg + 1'b1) : MR_W'(q_pos);
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/clf_back.sv -----
// Back part: Courant number, stencil sums and the result register.
`timescale 1ns / 1ps
`default_nettype none
module clf_back import clf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  job_t        job_in,
  input  logic        job_empty,
  output logic        job_pop,
  input  logic [31:0] time_step,
  output logic [31:0] flux,
  output logic [15:0] cell_index,
  output logic        last_out,
  output logic        out_valid,
  input  logic        out_ready
);

  localparam int SH     = Q_SHIFT - FRAC_BITS;
  localparam int NW     = 64 + SH;
  localparam int HW     = NW - 32;
  localparam int ACC_W  = 48;
  localparam int D3_W   = 48;
  localparam int D3_CYC = D3_W / DIG_W;

  localparam logic [2:0] ST_C2 = 3'd0;
  localparam logic [2:0] ST_C3 = 3'd1;
  localparam logic [2:0] ST_C4 = 3'd2;
  localparam logic [2:0] ST_TA = 3'd3;
  localparam logic [2:0] ST_TB = 3'd4;
  localparam logic [2:0] ST_TC = 3'd5;
  localparam logic [2:0] ST_TD = 3'd6;
  localparam logic [2:0] ST_T1 = 3'd1;
  localparam logic [2:0] ST_T2 = 3'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_NUM, S_DCHK, S_DIV, S_CSET, S_MSTART, S_MWAIT, S_D3, S_RES, S_OUT
  } state_t;

  state_t                    state;
  job_t                      job;
  logic [2:0]                step;
  logic [63:0]               num;
  logic [32:0]               rem;
  logic [31:0]               nlow;
  logic [31:0]               q;
  logic [4:0]                bcnt;
  logic signed [MY_W-1:0]    c;
  logic signed [MY_W-1:0]    c2;
  logic signed [MY_W-1:0]    c3;
  logic signed [MY_W-1:0]    c4;
  logic signed [ACC_W-1:0]   acc;
  logic [D3_W-1:0]           d3;
  logic [1:0]                r3;
  logic [2:0]                dcnt;
  logic                      dneg;
  logic                      mstart;

  logic [NW-1:0]             nfull;
  logic [33:0]               trial;
  logic [31:0]               shmag;
  logic [32:0]               lim;
  logic [32:0]               mag;
  logic signed [MY_W-1:0]    cm;
  logic signed [MX_W-1:0]    e0, e1, e2, e3;
  logic signed [MX_W-1:0]    x_sel;
  logic signed [MY_W-1:0]    y_sel;
  logic signed [MR_W-1:0]    mres;
  logic                      mdone;
  logic [MR_W-1:0]           tmag;
  logic [D3_W-1:0]           pre;
  logic [D3_W-1:0]           d3n;
  logic [1:0]                r3n;
  logic signed [ACC_W-1:0]   dterm;

  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > 48'sd2147483647) return 32'h7fffffff;
    else if (v < -48'sd2147483648) return 32'h80000000;
    else return v[31:0];
  endfunction

  clf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mstart),
    .x     (x_sel),
    .y     (y_sel),
    .res   (mres),
    .done  (mdone)
  );

  assign job_pop = (state == S_IDLE) && !job_empty;
  assign nfull   = {num, {SH{1'b0}}};
  assign trial   = {rem, nlow[31]};
  assign shmag   = job.sh[31] ? 32'(-job.sh) : 32'(job.sh);
  assign lim     = job.sh[31] ? 33'h080000000 : 33'h07fffffff;
  assign mag     = ({1'b0, q} > lim) ? lim : {1'b0, q};
  assign cm      = $signed(MY_W'(mag));
  assign e0      = MX_W'($signed(job.fa));
  assign e1      = MX_W'($signed(job.fb));
  assign e2      = MX_W'($signed(job.fc));
  assign e3      = MX_W'($signed(job.fd));
  assign tmag    = mres[MR_W-1] ? MR_W'(-mres) : MR_W'(mres);
  assign pre     = (step == ST_TA || step == ST_TC) ? D3_W'(tmag >> 2) : D3_W'(tmag >> 3);
  assign dterm   = dneg ? -$signed(ACC_W'(d3n)) : $signed(ACC_W'(d3n));

  always_comb begin
    x_sel = MX_W'(c);
    y_sel = c;
    if (job.kind == JOB_ORD4) begin
      case (step)
        ST_C2: x_sel = MX_W'(c);
        ST_C3: x_sel = MX_W'(c2);
        ST_C4: x_sel = MX_W'(c3);
        ST_TA: x_sel = -e0 + e1 * 7 + e2 * 7 - e3;
        ST_TB: begin
          x_sel = e0 - e1 * 15 + e2 * 15 - e3;
          y_sel = c2;
        end
        ST_TC: begin
          x_sel = e0 - e1 - e2 + e3;
          y_sel = c3;
        end
        ST_TD: begin
          x_sel = -e0 + e1 * 3 - e2 * 3 + e3;
          y_sel = c4;
        end
        default: x_sel = MX_W'(c);
      endcase
    end else begin
      case (step)
        ST_C2: x_sel = MX_W'(c);
        ST_T1: x_sel = e0 + e1;
        ST_T2: begin
          x_sel = e1 - e0;
          y_sel = c2;
        end
        default: x_sel = MX_W'(c);
      endcase
    end
  end

  // eight digits of a divide by three per cycle
  always_comb begin
    logic [2:0] t3;
    d3n = d3;
    r3n = r3;
    for (int i = 0; i < DIG_W; i++) begin
      t3  = {r3n, d3n[D3_W-1]};
      d3n = {d3n[D3_W-2:0], 1'b0};
      if (t3 >= 3'd3) begin
        r3n    = 2'(t3 - 3'd3);
        d3n[0] = 1'b1;
      end else begin
        r3n = t3[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mstart    <= 1'b0;
    end else begin
      mstart <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!job_empty) begin
            job  <= job_in;
            acc  <= '0;
            step <= ST_C2;
            if (job_in.kind == JOB_ZERO) begin
              flux       <= '0;
              cell_index <= job_in.idx;
              last_out   <= job_in.last;
              out_valid  <= 1'b1;
              state      <= S_OUT;
            end else begin
              state <= S_NUM;
            end
          end
        end
        S_NUM: begin
          num   <= 64'(shmag) * 64'(time_step);
          state <= S_DCHK;
        end
        S_DCHK: begin
          if (num == '0) begin
            q     <= '0;
            state <= S_CSET;
          end else if (job.dx == '0 || nfull[NW-1:32] >= HW'(job.dx)) begin
            q     <= '1;
            state <= S_CSET;
          end else begin
            rem   <= 33'(nfull[NW-1:32]);
            nlow  <= nfull[31:0];
            bcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (trial >= {1'b0, job.dx}) begin
            rem <= 33'(trial - {1'b0, job.dx});
            q   <= {q[30:0], 1'b1};
          end else begin
            rem <= trial[32:0];
            q   <= {q[30:0], 1'b0};
          end
          nlow <= {nlow[30:0], 1'b0};
          bcnt <= bcnt + 1'b1;
          if (bcnt == 5'd31) state <= S_CSET;
        end
        S_CSET: begin
          c     <= job.sh[31] ? -cm : cm;
          state <= S_MSTART;
        end
        S_MSTART: begin
          mstart <= 1'b1;
          state  <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mdone) begin
            if (job.kind == JOB_ORD4) begin
              case (step)
                ST_C2: begin
                  c2    <= MY_W'(mres);
                  step  <= step + 1'b1;
                  state <= S_MSTART;
                end
                ST_C3: begin
                  c3    <= MY_W'(mres);
                  step  <= step + 1'b1;
                  state <= S_MSTART;
                end
                ST_C4: begin
                  c4    <= MY_W'(mres);
                  step  <= step + 1'b1;
                  state <= S_MSTART;
                end
                default: begin
                  d3    <= pre;
                  r3    <= '0;
                  dcnt  <= '0;
                  dneg  <= mres[MR_W-1];
                  state <= S_D3;
                end
              endcase
            end else begin
              case (step)
                ST_C2: begin
                  c2    <= MY_W'(mres);
                  step  <= ST_T1;
                  state <= S_MSTART;
                end
                ST_T1: begin
                  acc   <= ACC_W'(mres);
                  step  <= ST_T2;
                  state <= S_MSTART;
                end
                default: begin
                  acc   <= acc - ACC_W'(mres);
                  state <= S_RES;
                end
              endcase
            end
          end
        end
        S_D3: begin
          d3   <= d3n;
          r3   <= r3n;
          dcnt <= dcnt + 1'b1;
          if (dcnt == 3'(D3_CYC - 1)) begin
            acc <= acc + dterm;
            if (step == ST_TD) begin
              state <= S_RES;
            end else begin
              step  <= step + 1'b1;
              state <= S_MSTART;
            end
          end
        end
        S_RES: begin
          flux       <= (job.kind == JOB_ORD4) ? sat32(acc) : sat32(acc >>> 1);
          cell_index <= job.idx;
          last_out   <= job.last;
          out_valid  <= 1'b1;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/conservative_lagrangian_flux_unit.sv -----
// Top level of the conservative Lagrangian interpolation flux unit.
// Cells of one pencil enter in order; each accepted cell from the third on yields the
// flux of the cell two places back, and the last cell also flushes the two trailing
// fluxes. The front takes a cell and then pushes each flux request it raises (up to
// three) into the queue, waiting while the queue is full, before taking the next.
// The back works one request at a time: a boundary flux is zero and goes straight to
// the result register; the work on an interior flux is set by the bit-serial Courant
// divider (skipped when the Courant number saturates or the shift product is zero),
// the shared multiplier (3 products at second order or 7 at fourth) and the divide by
// three for the 1/12 and 1/24 weights. A four-entry request queue lets the front run
// ahead of the back. Configuration must be written while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none
module conservative_lagrangian_flux_unit import clf_pkg::*; #(
  parameter int MAX_CELLS = 65536,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   sample,
  input  logic signed [31:0]   shift,
  input  logic signed [31:0]   grid_pos,
  input  logic                 last_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   flux,
  output logic [15:0]          cell_index,
  output logic                 last_out
);

  logic [31:0] time_step;
  logic        order_mode;
  job_t        push_data;
  logic        push;
  logic        full;
  job_t        head;
  logic        pop;
  logic        empty;
  logic [31:0] flux_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step  <= TIME_STEP_RESET;
      order_mode <= ORDER_MODE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_TIME_STEP:  time_step  <= cfg_wdata;
        REG_ORDER_MODE: order_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  clf_front #(.MAX_CELLS(MAX_CELLS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .shift      (shift),
    .grid_pos   (grid_pos),
    .last_in    (last_in),
    .order_mode (order_mode),
    .job_data   (push_data),
    .job_push   (push),
    .job_full   (full)
  );

  clf_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .full  (full),
    .pop   (pop),
    .rdata (head),
    .empty (empty)
  );

  clf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_in     (head),
    .job_empty  (empty),
    .job_pop    (pop),
    .time_step  (time_step),
    .flux       (flux_bits),
    .cell_index (cell_index),
    .last_out   (last_out),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  assign flux = $signed(flux_bits);

endmodule
`default_nettype wire
